// File: rtl/lpmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmf_pkg: shared types and constants of the length-prefixed message FIFO
// Sizes, command and status codes, sequencer states and ring arithmetic.
// ----------------------------------------------------------------------------
package lpmf_pkg;

  // Byte ring storage
  localparam int BUF_BYTES = 1024;
  localparam int PTR_W     = $clog2(BUF_BYTES);
  localparam int CAP_W     = PTR_W + 1;
  localparam int BYTE_W    = 8;

  // Field widths
  localparam int LEN_W    = 10;
  localparam int CNT_W    = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 11;

  // Header is a 2-byte little-endian length
  localparam logic [CAP_W-1:0] HDR_BYTES = CAP_W'(2);

  // Register defaults and limits
  localparam logic [CAP_W-1:0] CAP_MIN     = CAP_W'(3);
  localparam logic [CAP_W-1:0] CAP_MAX     = CAP_W'(BUF_BYTES);
  localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(1024);
  localparam logic [CNT_W-1:0] SLOTS_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(16);
  localparam logic [CNT_W-1:0] DROP_MAX    = CNT_W'(254);

  // Configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_SLOTS    = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_DISCARD = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOT_OPEN = 3'd3,
    ST_OFFSET   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_HDR1,
    S_FETCH0,
    S_FETCH1,
    S_FETCH2,
    S_RBYTE,
    S_DONE
  } state_t;

  // Advance a ring pointer by n bytes; p < cap and n <= cap
  function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] n,
                                                input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] sum;
    sum = CAP_W'(p) + n;
    if (sum >= cap) begin
      sum = sum - cap;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: rtl/lpmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lpmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/length_prefixed_message_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_fifo: message queue in a byte ring, drop-oldest
// Messages are stored as a 2-byte little-endian length plus payload. Opens
// evict the oldest messages until the new one fits in bytes and slots.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | request   | in_valid / in_stall  | cmd, msg_len, data_byte,
//          |           |                      | read_offset
//  out     | result    | out_valid / out_stall| status, read_byte, head_len,
//          |           |                      | msg_count, dropped
//  cfg     | write     | cfg_write            | cfg_index, cfg_data
//
// Steps: an admitted open drops the oldest messages while needed, then writes
// the header; each drop is a pop plus two header byte reads of the new head
// through the single registered RAM read port, with no reads for the drop
// that empties the queue; a discard that keeps messages fetches it likewise.
// Reset clears the queue pointers and counters; the byte store is not cleared.
// A new request is taken while the previous result still waits in the
// output register; out_stall only holds the sequencer in its last state.
// ----------------------------------------------------------------------------
module length_prefixed_message_fifo
  import lpmf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [LEN_W-1:0]    msg_len,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic [LEN_W-1:0]    read_offset,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [BYTE_W-1:0]   read_byte,
  output logic [LEN_W-1:0]    head_len,
  output logic [CNT_W-1:0]    msg_count,
  output logic [CNT_W-1:0]    dropped,
  // configuration
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  state_t state, state_next;

  // configuration, already saturated
  logic [CAP_W-1:0] cap;
  logic [CNT_W-1:0] slots;

  // queue state
  logic [PTR_W-1:0] read_ptr;
  logic [PTR_W-1:0] write_ptr;
  logic [CAP_W-1:0] used_bytes;
  logic [CNT_W-1:0] cnt;
  logic             open_flag;
  logic [LEN_W-1:0] bytes_left;
  logic [PTR_W-1:0] open_start;
  logic [LEN_W-1:0] open_len;
  logic [LEN_W-1:0] hlen;

  // current request
  cmd_t             cmd_r;
  logic [LEN_W-1:0] len_r;
  status_t          status_r;
  logic [BYTE_W-1:0] rbyte_r;
  logic [CNT_W-1:0] drop_r;

  // RAM port
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [PTR_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic             accept;
  logic             out_free;
  cmd_t             cmd_in;
  logic             too_long;
  logic [CAP_W-1:0] pop_n;
  logic [PTR_W-1:0] pop_rp;
  logic [CAP_W-1:0] pop_used;
  logic [CAP_W-1:0] part;
  logic [CAP_W-1:0] used_abandon;
  logic [CAP_W-1:0] need;
  logic             drop_cond;
  logic             rd_ok;
  logic [CAP_W-1:0] cap_in;
  logic [CNT_W-1:0] slots_in;

  assign cmd_in   = cmd_t'(cmd);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // open sizing
  assign too_long = (CAP_W'(msg_len) + HDR_BYTES) > cap;
  assign need     = CAP_W'(len_r) + HDR_BYTES;

  // head pop arithmetic
  assign pop_n    = CAP_W'(hlen) + HDR_BYTES;
  assign pop_rp   = ring_adv(read_ptr, pop_n, cap);
  assign pop_used = (used_bytes >= pop_n) ? used_bytes - pop_n : '0;

  // abandoned partial message size, modulo ring size
  assign part = (write_ptr >= open_start) ?
                CAP_W'(write_ptr) - CAP_W'(open_start) :
                CAP_W'(write_ptr) + cap - CAP_W'(open_start);
  assign used_abandon = (used_bytes >= part) ? used_bytes - part : '0;

  // evict while room or slots are short
  assign drop_cond = (cnt != '0) &&
                     ((need > cap - used_bytes) || (cnt == slots - CNT_W'(1)));

  assign rd_ok = (cnt != '0) && (read_offset < hlen);

  // saturated register values
  assign cap_in = (cfg_data < CAP_MIN) ? CAP_MIN :
                  (cfg_data > CAP_MAX) ? CAP_MAX : cfg_data;
  assign slots_in = (cfg_data[CNT_W-1:0] < SLOTS_MIN) ? SLOTS_MIN : cfg_data[CNT_W-1:0];

  lpmf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_OPEN:    state_next = too_long ? S_DONE : S_DROP;
            CMD_WRITE:   state_next = S_DONE;
            CMD_READ:    state_next = rd_ok ? S_RBYTE : S_DONE;
            CMD_DISCARD: state_next = (cnt > CNT_W'(1)) ? S_FETCH0 : S_DONE;
          endcase
        end
      end
      S_DROP: begin
        if (drop_cond) begin
          state_next = (cnt > CNT_W'(1)) ? S_FETCH0 : S_DROP;
        end else begin
          state_next = S_HDR1;
        end
      end
      S_HDR1:   state_next = S_DONE;
      S_FETCH0: state_next = S_FETCH1;
      S_FETCH1: state_next = S_FETCH2;
      S_FETCH2: state_next = (cmd_r == CMD_OPEN) ? S_DROP : S_DONE;
      S_RBYTE:  state_next = S_DONE;
      S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM controls and request stall
  always_comb begin
    in_stall  = (state != S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = write_ptr;
    mem_wdata = data_byte;
    mem_raddr = read_ptr;
    unique case (state)
      S_IDLE: begin
        mem_raddr = ring_adv(read_ptr, CAP_W'(read_offset) + HDR_BYTES, cap);
        mem_we    = accept && (cmd_in == CMD_WRITE) && open_flag;
      end
      S_DROP: begin
        mem_we    = !drop_cond;
        mem_wdata = len_r[BYTE_W-1:0];
      end
      S_HDR1: begin
        mem_we    = 1'b1;
        mem_waddr = ring_adv(write_ptr, CAP_W'(1), cap);
        mem_wdata = BYTE_W'(len_r[LEN_W-1:BYTE_W]);
      end
      S_FETCH0: mem_raddr = read_ptr;
      S_FETCH1: mem_raddr = ring_adv(read_ptr, CAP_W'(1), cap);
      default: begin
        mem_raddr = read_ptr;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // queue state and request datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CAP_RESET;
      slots      <= SLOTS_RESET;
      read_ptr   <= '0;
      write_ptr  <= '0;
      used_bytes <= '0;
      cnt        <= '0;
      open_flag  <= 1'b0;
      bytes_left <= '0;
      open_start <= '0;
      open_len   <= '0;
      hlen       <= '0;
    end else if (cfg_write) begin
      // any register write empties the queue
      if (cfg_index == REG_CAPACITY) begin
        cap <= cap_in;
      end else begin
        slots <= slots_in;
      end
      read_ptr   <= '0;
      write_ptr  <= '0;
      used_bytes <= '0;
      cnt        <= '0;
      open_flag  <= 1'b0;
      bytes_left <= '0;
      open_start <= '0;
      open_len   <= '0;
      hlen       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd_in)
              CMD_OPEN: begin
                // drop the partial message before admission
                if (!too_long && open_flag) begin
                  write_ptr  <= open_start;
                  used_bytes <= used_abandon;
                  open_flag  <= 1'b0;
                  bytes_left <= '0;
                end
              end
              CMD_WRITE: begin
                if (open_flag) begin
                  write_ptr  <= ring_adv(write_ptr, CAP_W'(1), cap);
                  used_bytes <= used_bytes + CAP_W'(1);
                  bytes_left <= bytes_left - LEN_W'(1);
                  if (bytes_left == LEN_W'(1)) begin
                    cnt       <= cnt + CNT_W'(1);
                    open_flag <= 1'b0;
                    if (cnt == '0) begin
                      hlen <= open_len;
                    end
                  end
                end
              end
              CMD_READ: begin
              end
              CMD_DISCARD: begin
                if (cnt != '0) begin
                  read_ptr   <= pop_rp;
                  used_bytes <= pop_used;
                  cnt        <= cnt - CNT_W'(1);
                  if (cnt == CNT_W'(1)) begin
                    hlen <= '0;
                  end
                end
              end
            endcase
          end
        end
        S_DROP: begin
          if (drop_cond) begin
            read_ptr   <= pop_rp;
            used_bytes <= pop_used;
            cnt        <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              hlen <= '0;
            end
          end
        end
        S_HDR1: begin
          open_start <= write_ptr;
          write_ptr  <= ring_adv(write_ptr, HDR_BYTES, cap);
          used_bytes <= used_bytes + HDR_BYTES;
          open_len   <= len_r;
          if (len_r == '0) begin
            // empty message commits at once
            cnt <= cnt + CNT_W'(1);
          end else begin
            open_flag  <= 1'b1;
            bytes_left <= len_r;
          end
        end
        S_FETCH1: hlen[BYTE_W-1:0] <= mem_rdata;
        S_FETCH2: hlen[LEN_W-1:BYTE_W] <= mem_rdata[LEN_W-BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // per-request result fields
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      cmd_r   <= cmd_in;
      len_r   <= msg_len;
      rbyte_r <= '0;
      drop_r  <= '0;
      unique case (cmd_in)
        CMD_OPEN:    status_r <= too_long ? ST_TOO_LONG : ST_OK;
        CMD_WRITE:   status_r <= open_flag ? ST_OK : ST_NOT_OPEN;
        CMD_READ:    status_r <= (cnt == '0) ? ST_EMPTY : (rd_ok ? ST_OK : ST_OFFSET);
        CMD_DISCARD: status_r <= (cnt == '0) ? ST_EMPTY : ST_OK;
      endcase
    end else if (state == S_DROP && drop_cond && drop_r < DROP_MAX) begin
      drop_r <= drop_r + CNT_W'(1);
    end else if (state == S_RBYTE) begin
      rbyte_r <= mem_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status    <= status_r;
      read_byte <= rbyte_r;
      head_len  <= hlen;
      msg_count <= cnt;
      dropped   <= drop_r;
    end
  end

  // checks
  a_used_fits: assert property (@(posedge clk) disable iff (rst)
    used_bytes <= cap)
    else $error("used bytes exceed ring size");

  a_slots_fit: assert property (@(posedge clk) disable iff (rst)
    cnt < slots)
    else $error("message count reached slot ring size");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |-> (hlen == '0))
    else $error("head length cached while queue empty");

  a_open_left: assert property (@(posedge clk) disable iff (rst)
    open_flag |-> (bytes_left != '0))
    else $error("open message with no bytes left");

endmodule
